// ===== sv/cdbm_pkg.sv =====
package cdbm_pkg;

    localparam int TIME_W = 48;
    localparam int RATE_W = 32;
    localparam int CNT_W  = 32;
    localparam int THR_W  = 15;
    localparam logic [14:0] THR_RESET = 15'd140;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_COUNTED   = 3'd1;
    localparam logic [2:0] ST_OWN_FMT   = 3'd2;
    localparam logic [2:0] ST_NEXT_FMT  = 3'd3;
    localparam logic [2:0] ST_BELOW     = 3'd4;
    localparam logic [2:0] ST_NO_MATCH  = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [RATE_W-1:0] bitrate;
        logic              fmt;
        logic [CNT_W-1:0]  count;
    } rec_t;

endpackage

// ===== sv/cdbm_cell.sv =====
module cdbm_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  cdbm_pkg::rec_t  rec_in,
    input  logic            load,
    input  cdbm_pkg::rec_t  load_rec,
    output cdbm_pkg::rec_t  rec_out
);

    cdbm_pkg::rec_t rec_reg;
    cdbm_pkg::rec_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (load)
        begin
            rec_next = load_rec;
        end
        else if (shift)
        begin
            rec_next = rec_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

// ===== sv/chunk_delay_bitrate_map.sv =====
// Channel   Direction  Signals
// in        input      in_valid, in_ready, mode, time_ms, chunk_bitrate, format_changed, delay_ms
// out       output     out_valid, out_ready, status, hit_index, max_bitrate_no_delay
// cfg       input      cfg_valid, cfg_ready, cfg_data
// Each item passes in order through an accept state, one rotation of the ring of cells to
// scan and update, an apply state, a second rotation to find the lowest delayed bitrate,
// and the output transfer.
// Reset clears all records, the write pointer and the threshold to 140.
// A finished result waits in the output register; the next item is taken once it leaves.
module chunk_delay_bitrate_map
#(
    parameter int RECORDS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [47:0] time_ms,
    input  logic [31:0] chunk_bitrate,
    input  logic        format_changed,
    input  logic signed [15:0] delay_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  hit_index,
    output logic [31:0] max_bitrate_no_delay,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);

    localparam int IW = (RECORDS > 1) ? $clog2(RECORDS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} state_t;

    state_t            state_reg;
    logic [IW-1:0]     step_reg;
    logic [IW-1:0]     wp_reg;
    logic [14:0]       thr_reg;
    logic [1:0]        mode_reg;
    logic [47:0]       time_reg;
    logic [31:0]       rate_reg;
    logic              fmt_reg;
    logic              above_reg;
    logic              found_reg;
    logic [IW-1:0]     hit_reg;
    logic              hit_fmt_reg;
    logic [47:0]       hit_end_reg;
    logic              chk_next_reg;
    logic              next_drop_reg;
    logic [31:0]       low_reg;
    logic [2:0]        status_reg;
    logic [3:0]        hidx_reg;
    logic [31:0]       maxb_reg;
    logic              out_valid_reg;

    cdbm_pkg::rec_t    chain [RECORDS];
    cdbm_pkg::rec_t    head_mod;
    logic              load_v [RECORDS];
    cdbm_pkg::rec_t    load_r [RECORDS];
    logic              shift;
    cdbm_pkg::rec_t    h;
    logic              hvalid;
    logic              match;
    logic              cnt_cond;
    logic              next_drop_now;

    assign shift = (state_reg == S_SCAN) || (state_reg == S_OUT);
    assign h = chain[0];
    assign hvalid = (h.end_time != '0);
    assign match = hvalid && (time_reg >= h.start_time) && (time_reg <= h.end_time);
    assign next_drop_now = chk_next_reg ? ((h.start_time > hit_end_reg) && h.fmt)
                                        : next_drop_reg;

    always_comb
    begin
        head_mod = h;
        if (state_reg == S_SCAN)
        begin
            if (mode_reg == cdbm_pkg::MODE_CLEAR)
            begin
                head_mod.count = '0;
            end
            else if (mode_reg == cdbm_pkg::MODE_START && step_reg == wp_reg)
            begin
                head_mod.start_time = time_reg;
                head_mod.end_time = '1;
                head_mod.bitrate = rate_reg;
                head_mod.fmt = fmt_reg;
                head_mod.count = '0;
            end
            else if (mode_reg == cdbm_pkg::MODE_END && step_reg == wp_reg)
            begin
                head_mod.end_time = time_reg;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < RECORDS; g++)
        begin : g_cell
            cdbm_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .rec_in   ((g == RECORDS - 1) ? head_mod : chain[(g + 1) % RECORDS]),
                .load     (load_v[g]),
                .load_rec (load_r[g]),
                .rec_out  (chain[g])
            );
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < RECORDS; k++)
        begin
            load_v[k] = 1'b0;
            load_r[k] = chain[k];
        end
        cnt_cond = (state_reg == S_APPLY) && (mode_reg == cdbm_pkg::MODE_REPORT) &&
                   found_reg && above_reg && !hit_fmt_reg && !next_drop_now;
        for (int k = 0; k < RECORDS; k++)
        begin
            if (cnt_cond && hit_reg == IW'(k))
            begin
                load_v[k] = 1'b1;
                if (chain[k].count != '1)
                begin
                    load_r[k].count = chain[k].count + 32'd1;
                end
            end
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign hit_index = hidx_reg;
    assign max_bitrate_no_delay = maxb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            wp_reg <= '0;
            thr_reg <= cdbm_pkg::THR_RESET;
            out_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            chk_next_reg <= 1'b0;
            next_drop_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg <= mode;
                        time_reg <= time_ms;
                        rate_reg <= chunk_bitrate;
                        fmt_reg <= format_changed;
                        above_reg <= ($signed({delay_ms[15], delay_ms}) >=
                                      $signed({2'b00, thr_reg}));
                        found_reg <= 1'b0;
                        chk_next_reg <= 1'b0;
                        next_drop_reg <= 1'b0;
                        hit_reg <= '0;
                        step_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (chk_next_reg)
                    begin
                        next_drop_reg <= (h.start_time > hit_end_reg) && h.fmt;
                        chk_next_reg <= 1'b0;
                    end
                    if (!found_reg && match)
                    begin
                        found_reg <= 1'b1;
                        hit_reg <= step_reg;
                        hit_fmt_reg <= h.fmt;
                        hit_end_reg <= h.end_time;
                        chk_next_reg <= 1'b1;
                    end
                    if (step_reg == IW'(RECORDS - 1))
                    begin
                        state_reg <= S_APPLY;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == IW'(RECORDS - 1))
                    begin
                        step_reg <= '0;
                    end
                end
                S_APPLY:
                begin
                    if (chk_next_reg)
                    begin
                        next_drop_reg <= (h.start_time > hit_end_reg) && h.fmt;
                        chk_next_reg <= 1'b0;
                    end
                    if (mode_reg == cdbm_pkg::MODE_END)
                    begin
                        wp_reg <= (wp_reg == IW'(RECORDS - 1)) ? '0 : wp_reg + 1'b1;
                    end
                    low_reg <= '1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (step_reg == '0)
                    begin
                        if (mode_reg != cdbm_pkg::MODE_REPORT)
                        begin
                            status_reg <= cdbm_pkg::ST_DONE;
                            hidx_reg <= '0;
                        end
                        else if (!found_reg)
                        begin
                            status_reg <= cdbm_pkg::ST_NO_MATCH;
                            hidx_reg <= '0;
                        end
                        else
                        begin
                            hidx_reg <= 4'(hit_reg);
                            if (!above_reg)
                            begin
                                status_reg <= cdbm_pkg::ST_BELOW;
                            end
                            else if (hit_fmt_reg)
                            begin
                                status_reg <= cdbm_pkg::ST_OWN_FMT;
                            end
                            else if (next_drop_reg)
                            begin
                                status_reg <= cdbm_pkg::ST_NEXT_FMT;
                            end
                            else
                            begin
                                status_reg <= cdbm_pkg::ST_COUNTED;
                            end
                        end
                    end
                    state_reg <= S_OUT;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_OUT)
            begin
                if (h.end_time != '0 && h.count != '0 && h.bitrate < low_reg)
                begin
                    low_reg <= h.bitrate;
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == IW'(RECORDS - 1))
                begin
                    step_reg <= '0;
                    maxb_reg <= ((h.end_time != '0 && h.count != '0 && h.bitrate < low_reg)
                                 ? h.bitrate : low_reg) - 32'd1;
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
            end
        end
    end

endmodule

// ===== test/tb_chunk_delay_bitrate_map.sv =====
`timescale 1ns / 100ps

module tb_chunk_delay_bitrate_map;

    localparam int NREC = 16;
    localparam int RANDOM_ITEMS = 1350;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [47:0] TIME_ALL_ONES = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic [47:0]        time_ms;
        logic [31:0]        chunk_bitrate;
        logic               format_changed;
        logic signed [15:0] delay_ms;
    } chunk_event_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  hit_index;
        logic [31:0] max_bitrate_no_delay;
    } map_result_t;

    typedef struct {
        chunk_event_t ev;
        logic         known;
        map_result_t  res;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [47:0] time_ms;
    logic [31:0] chunk_bitrate;
    logic        format_changed;
    logic signed [15:0] delay_ms;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [3:0]  hit_index;
    logic [31:0] max_bitrate_no_delay;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;

    logic [47:0] chunk_start [NREC];
    logic [47:0] chunk_end [NREC];
    logic [31:0] chunk_rate [NREC];
    logic        chunk_fmt [NREC];
    logic [31:0] chunk_delays [NREC];
    logic [3:0]  open_slot;
    logic [14:0] threshold;

    map_result_t expected_results[$];
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          counted_reports;
    longint      cycles;
    logic [47:0] recent_times[$];

    chunk_delay_bitrate_map #(.RECORDS(NREC)) i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .mode                 (mode),
        .time_ms              (time_ms),
        .chunk_bitrate        (chunk_bitrate),
        .format_changed       (format_changed),
        .delay_ms             (delay_ms),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .hit_index            (hit_index),
        .max_bitrate_no_delay (max_bitrate_no_delay),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] lowest_delayed_rate_minus_one();
        logic [31:0] low;
        low = 32'hFFFF_FFFF;
        for (int i = 0; i < NREC; i++)
        begin
            if (chunk_end[i] != 0 && chunk_delays[i] != 0 && chunk_rate[i] < low)
            begin
                low = chunk_rate[i];
            end
        end
        return low - 32'd1;
    endfunction

    function automatic map_result_t apply_chunk_event(chunk_event_t ev);
        map_result_t r;
        int          hit;
        int          nx;
        logic        found;
        r = '0;
        hit = 0;
        found = 1'b0;
        case (ev.mode)
            cdbm_pkg::MODE_START:
            begin
                chunk_start[open_slot] = ev.time_ms;
                chunk_end[open_slot] = TIME_ALL_ONES;
                chunk_rate[open_slot] = ev.chunk_bitrate;
                chunk_fmt[open_slot] = ev.format_changed;
                chunk_delays[open_slot] = 0;
                r.status = cdbm_pkg::ST_DONE;
            end
            cdbm_pkg::MODE_END:
            begin
                chunk_end[open_slot] = ev.time_ms;
                open_slot = (open_slot == NREC - 1) ? 4'd0 : open_slot + 4'd1;
                r.status = cdbm_pkg::ST_DONE;
            end
            cdbm_pkg::MODE_REPORT:
            begin
                for (int i = 0; i < NREC; i++)
                begin
                    if (!found && chunk_end[i] != 0 && ev.time_ms >= chunk_start[i]
                        && ev.time_ms <= chunk_end[i])
                    begin
                        found = 1'b1;
                        hit = i;
                    end
                end
                if (!found)
                begin
                    r.status = cdbm_pkg::ST_NO_MATCH;
                end
                else if (int'(ev.delay_ms) < int'(threshold))
                begin
                    r.status = cdbm_pkg::ST_BELOW;
                    r.hit_index = hit[3:0];
                end
                else
                begin
                    r.hit_index = hit[3:0];
                    nx = (hit == NREC - 1) ? 0 : hit + 1;
                    if (chunk_fmt[hit])
                    begin
                        r.status = cdbm_pkg::ST_OWN_FMT;
                    end
                    else if (chunk_start[nx] > chunk_end[hit] && chunk_fmt[nx])
                    begin
                        r.status = cdbm_pkg::ST_NEXT_FMT;
                    end
                    else
                    begin
                        if (chunk_delays[hit] != 32'hFFFF_FFFF)
                        begin
                            chunk_delays[hit] = chunk_delays[hit] + 1;
                        end
                        r.status = cdbm_pkg::ST_COUNTED;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < NREC; i++)
                begin
                    chunk_delays[i] = 0;
                end
                r.status = cdbm_pkg::ST_DONE;
            end
        endcase
        r.max_bitrate_no_delay = lowest_delayed_rate_minus_one();
        return r;
    endfunction

    task automatic send_chunk_event(chunk_event_t ev, logic known, map_result_t typed);
        map_result_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        r = apply_chunk_event(ev);
        if (known && r != typed)
        begin
            $display("directed row disagrees with prediction: typed %h predicted %h", typed, r);
            mismatches++;
        end
        expected_results.push_back(r);
        if (r.status == cdbm_pkg::ST_COUNTED)
        begin
            counted_reports++;
        end
        in_valid <= 1'b1;
        mode <= ev.mode;
        time_ms <= ev.time_ms;
        chunk_bitrate <= ev.chunk_bitrate;
        format_changed <= ev.format_changed;
        delay_ms <= ev.delay_ms;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic write_threshold(logic [14:0] value);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (NREC + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        threshold = value;
    endtask

    function automatic chunk_event_t random_chunk_event();
        chunk_event_t ev;
        int           pick;
        ev.mode = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            ev.mode = cdbm_pkg::MODE_START;
        end
        else if (pick < 24)
        begin
            ev.mode = cdbm_pkg::MODE_END;
        end
        else if (pick < 90)
        begin
            ev.mode = cdbm_pkg::MODE_REPORT;
        end
        else if (pick < 93)
        begin
            ev.mode = cdbm_pkg::MODE_CLEAR;
        end
        ev.time_ms = 48'({$urandom, $urandom});
        if ($urandom_range(9) != 0)
        begin
            ev.time_ms = 48'($urandom_range(4000));
            if (recent_times.size() > 0 && $urandom_range(2) != 0)
            begin
                ev.time_ms = recent_times[$urandom_range(recent_times.size() - 1)]
                    + 48'($urandom_range(20));
            end
        end
        if ($urandom_range(30) == 0)
        begin
            ev.time_ms = 0;
        end
        ev.chunk_bitrate = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(5000));
        ev.format_changed = ($urandom_range(4) == 0);
        ev.delay_ms = 16'($urandom);
        if ($urandom_range(2) != 0)
        begin
            ev.delay_ms = 16'(int'(threshold) - 20 + $urandom_range(60));
        end
        if (ev.mode != cdbm_pkg::MODE_REPORT)
        begin
            recent_times.push_back(ev.time_ms);
            if (recent_times.size() > 32)
            begin
                void'(recent_times.pop_front());
            end
        end
        return ev;
    endfunction

    always @(posedge clk)
    begin
        map_result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{status, hit_index, max_bitrate_no_delay};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected transfer: %h", got);
                    end
                end
                else
                begin
                    if (got != expected_results[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d: expected status %0d hit %0d rate %h, got %0d %0d %h",
                                results_seen, expected_results[0].status,
                                expected_results[0].hit_index,
                                expected_results[0].max_bitrate_no_delay,
                                got.status, got.hit_index, got.max_bitrate_no_delay);
                        end
                    end
                    void'(expected_results.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    directed_row_t rows[$];

    function automatic chunk_event_t ce(logic [1:0] m, logic [47:0] t, logic [31:0] b,
                                        logic f, logic signed [15:0] d);
        chunk_event_t ev;
        ev = '{m, t, b, f, d};
        return ev;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = cdbm_pkg::MODE_START;
        time_ms = '0;
        chunk_bitrate = '0;
        format_changed = 1'b0;
        delay_ms = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        counted_reports = 0;
        cycles = 0;
        for (int i = 0; i < NREC; i++)
        begin
            chunk_start[i] = 0;
            chunk_end[i] = 0;
            chunk_rate[i] = 0;
            chunk_fmt[i] = 0;
            chunk_delays[i] = 0;
        end
        open_slot = 0;
        threshold = cdbm_pkg::THR_RESET;

        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'd0, 0, 0, 16'sd32767), 1'b1,
                         '{cdbm_pkg::ST_NO_MATCH, 4'd0, 32'hFFFF_FFFE}});
        rows.push_back('{ce(cdbm_pkg::MODE_START, 48'd100, 32'd5000, 0, 0), 1'b1,
                         '{cdbm_pkg::ST_DONE, 4'd0, 32'hFFFF_FFFE}});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, TIME_ALL_ONES, 0, 1, 16'sd140), 1'b1,
                         '{cdbm_pkg::ST_COUNTED, 4'd0, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'd100, 0, 0, 16'sd139), 1'b1,
                         '{cdbm_pkg::ST_BELOW, 4'd0, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'd100, 0, 0, -16'sd32768), 1'b1,
                         '{cdbm_pkg::ST_BELOW, 4'd0, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'd99, 0, 0, 16'sd500), 1'b1,
                         '{cdbm_pkg::ST_NO_MATCH, 4'd0, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_END, 48'd200, 32'hFFFF_FFFF, 1, -16'sd1), 1'b1,
                         '{cdbm_pkg::ST_DONE, 4'd0, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_START, 48'd201, 32'hFFFF_FFFF, 1, 0), 1'b0, '0});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'd150, 0, 0, 16'sd200), 1'b1,
                         '{cdbm_pkg::ST_NEXT_FMT, 4'd0, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'd250, 0, 0, 16'sd200), 1'b1,
                         '{cdbm_pkg::ST_OWN_FMT, 4'd1, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_END, 48'd0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'd250, 0, 0, 16'sd200), 1'b1,
                         '{cdbm_pkg::ST_NO_MATCH, 4'd0, 32'd4999}});
        rows.push_back('{ce(cdbm_pkg::MODE_CLEAR, TIME_ALL_ONES, 32'hFFFF_FFFF, 1, -16'sd1),
                         1'b1, '{cdbm_pkg::ST_DONE, 4'd0, 32'hFFFF_FFFE}});
        rows.push_back('{ce(cdbm_pkg::MODE_END, 48'd300, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ce(cdbm_pkg::MODE_START, 48'd0, 32'd0, 0, 0), 1'b0, '0});
        rows.push_back('{ce(cdbm_pkg::MODE_END, 48'hAAAA_AAAA_AAAA, 0, 0, 0), 1'b0, '0});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'h5555_5555_5555, 0, 0, 16'sh5555),
                         1'b0, '0});
        rows.push_back('{ce(cdbm_pkg::MODE_START, 48'h5555_5555_5555, 32'h5555_5555, 0, 0),
                         1'b0, '0});
        rows.push_back('{ce(cdbm_pkg::MODE_REPORT, 48'h5555_5555_5556, 0, 0, 16'shAAA),
                         1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_chunk_event(rows[i].ev, rows[i].known, rows[i].res);
        end

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_threshold(15'd0);
                1: write_threshold(15'h7FFF);
                2: write_threshold(15'd140);
                3: write_threshold(15'($urandom_range(300)));
                default: write_threshold(15'd50);
            endcase
            sender_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 61 : 0;
            receiver_idle_pct = (phase < 2) ? 61 : (phase < 4) ? 25 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
            begin
                send_chunk_event(random_chunk_event(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3 * NREC) @(posedge clk);
        $display("Sent %0d chunk events, checked %0d results, %0d reports counted a delay.",
                 items_sent, results_seen, counted_reports);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cdbm_pkg.sv
sv/cdbm_cell.sv
sv/chunk_delay_bitrate_map.sv
test/tb_chunk_delay_bitrate_map.sv
